### design/pkes_pkg.sv
// Package for the panel key and encoder scanner: word types, codes and tables.
// Used by every module of the scanner; depends on nothing else.
package pkes_pkg;

  // table geometry and field widths
  localparam int TABLE_ROWS  = 6;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;

  // operation codes
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_CONFIRM  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENCODER_CONFIRM = 1'b1;

  // reset values of the confirm counts
  localparam logic [3:0] BUTTON_CONFIRM_RESET  = 4'd3;
  localparam logic [3:0] ENCODER_CONFIRM_RESET = 4'd5;

  // host command codes (low 7 bits)
  localparam logic [6:0] CMD_RELAY_ONE  = 7'd1;
  localparam logic [6:0] CMD_RELAY_SYNC = 7'd3;
  localparam logic [6:0] CMD_POWER_OFF  = 7'd4;

  // special key codes
  localparam logic [7:0] POWER_KEY     = 8'hFF;
  localparam logic [7:0] POWER_ON_CODE = 8'h8B;
  localparam logic [7:0] RELEASE_MASK  = 8'h7F;
  localparam logic [7:0] RIGHT_FLAG    = 8'h80;
  localparam logic [3:0] COUNT_MAX     = 4'd15;

  // input word, fields in order
  typedef struct packed {
    logic       operation;
    logic [2:0] row;
    logic [7:0] sample;
    logic [7:0] command;
  } in_word_t;

  // result word, fields in order
  typedef struct packed {
    logic       code_valid;
    logic [7:0] key_code;
    logic       relay_one_low;
    logic       relay_two_low;
    logic       relay_sync_low;
    logic       power_on;
  } out_word_t;

  // classified word passed from front to back
  typedef struct packed {
    logic       is_command;
    logic       row_ok;
    logic [2:0] row;
    logic [7:0] sample;
    logic [7:0] command;
    logic       button_need;
    logic       press_found;
    logic [7:0] press_code;
    logic [2:0] press_bit;
    logic [7:0] enc_first;
    logic [7:0] enc_second;
  } cls_word_t;

  // button bits of each row
  function automatic logic [7:0] button_mask(input logic [2:0] r);
    logic [7:0] m;
    case (r)
      3'd3:    m = 8'h91;
      3'd4:    m = 8'hBF;
      default: m = 8'h81;
    endcase
    return m;
  endfunction

  // press code of a row and bit, zero where no button sits
  function automatic logic [7:0] press_code(input logic [2:0] r, input logic [2:0] b);
    logic [7:0] c;
    c = 8'h00;
    case (r)
      3'd0: begin
        if (b == 3'd0) c = 8'h81;
        if (b == 3'd7) c = 8'h8D;
      end
      3'd1: begin
        if (b == 3'd0) c = 8'h83;
        if (b == 3'd7) c = 8'h8E;
      end
      3'd2: begin
        if (b == 3'd0) c = 8'h85;
        if (b == 3'd7) c = 8'h8F;
      end
      3'd3: begin
        if (b == 3'd0) c = 8'h87;
        if (b == 3'd4) c = 8'h88;
        if (b == 3'd7) c = 8'h90;
      end
      3'd4: begin
        case (b)
          3'd0:    c = 8'h89;
          3'd1:    c = 8'h8A;
          3'd2:    c = 8'h84;
          3'd3:    c = 8'h8C;
          3'd4:    c = 8'h86;
          3'd5:    c = 8'h82;
          3'd7:    c = 8'h91;
          default: c = 8'h00;
        endcase
      end
      3'd5: begin
        if (b == 3'd0) c = POWER_KEY;
        if (b == 3'd7) c = 8'h92;
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // base code of the encoder on bits 1 and 2
  function automatic logic [7:0] enc_first_base(input logic [2:0] r);
    logic [7:0] c;
    case (r)
      3'd0:    c = 8'h14;
      3'd1:    c = 8'h16;
      3'd2:    c = 8'h18;
      3'd3:    c = 8'h1A;
      3'd5:    c = 8'h1B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // base code of the encoder on bits 4 and 5
  function automatic logic [7:0] enc_second_base(input logic [2:0] r);
    logic [7:0] c;
    case (r)
      3'd0:    c = 8'h15;
      3'd1:    c = 8'h17;
      3'd2:    c = 8'h19;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### design/pkes_front.sv
// Front end of the scanner: takes input words and classifies them by table lookup.
// Depends on pkes_pkg; feeds pkes_queue.
module pkes_front #(
  parameter int SCAN_ROWS = 6
) (
  input  pkes_pkg::in_word_t  word,
  output pkes_pkg::cls_word_t cls
);

  localparam int ROWS_USED = (SCAN_ROWS < pkes_pkg::TABLE_ROWS) ? SCAN_ROWS
                                                                 : pkes_pkg::TABLE_ROWS;

  logic [7:0] mask;
  logic       found;
  logic [7:0] code;
  logic [2:0] bit_idx;

  // first pressed button bit, lowest bit wins
  always_comb begin
    found   = 1'b0;
    code    = 8'h00;
    bit_idx = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (pkes_pkg::press_code(word.row, 3'(b)) != 8'h00 && !word.sample[b]) begin
        found   = 1'b1;
        code    = pkes_pkg::press_code(word.row, 3'(b));
        bit_idx = 3'(b);
      end
    end
  end

  assign mask = pkes_pkg::button_mask(word.row);

  // classified word
  always_comb begin
    cls.is_command  = (word.operation == pkes_pkg::OP_COMMAND);
    cls.row_ok      = (word.row < 3'(ROWS_USED));
    cls.row         = word.row;
    cls.sample      = word.sample;
    cls.command     = word.command;
    cls.button_need = ((word.sample & mask) != mask);
    cls.press_found = found;
    cls.press_code  = code;
    cls.press_bit   = bit_idx;
    cls.enc_first   = pkes_pkg::enc_first_base(word.row);
    cls.enc_second  = pkes_pkg::enc_second_base(word.row);
  end

endmodule

### design/pkes_queue.sv
// Two-entry queue of classified words between front and back of the scanner.
// Depends on pkes_pkg.
module pkes_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pkes_pkg::cls_word_t push_word,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output pkes_pkg::cls_word_t pop_word
);

  localparam int DEPTH = 2;

  pkes_pkg::cls_word_t entries [DEPTH];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;

  assign full      = (count == 2'(DEPTH));
  assign not_empty = (count != 2'd0);
  assign pop_word  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'(DEPTH) || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0)
    else $error("queue read while empty");
`endif

endmodule

### design/pkes_back.sv
// Back end of the scanner: row state, qualifying, key hold, encoders, relays, power.
// Depends on pkes_pkg; drains pkes_queue into a one-word output register.
module pkes_back #(
  parameter int SCAN_ROWS = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [pkes_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pkes_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 q_valid,
  input  pkes_pkg::cls_word_t                  q_word,
  output logic                                 q_pop,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output pkes_pkg::out_word_t                  result
);

  localparam int ROWS_USED = (SCAN_ROWS < pkes_pkg::TABLE_ROWS) ? SCAN_ROWS
                                                                 : pkes_pkg::TABLE_ROWS;
  localparam int ROW_IDX_W = (ROWS_USED > 1) ? $clog2(ROWS_USED) : 1;

  // state
  logic [7:0] row_previous [ROWS_USED];
  logic [3:0] button_confirm;
  logic [3:0] encoder_confirm;
  logic [2:0] qualify_row,   qualify_row_next;
  logic [7:0] qualify_value, qualify_value_next;
  logic [3:0] qualify_count, qualify_count_next;
  logic       key_held,      key_held_next;
  logic [2:0] held_row,      held_row_next;
  logic [2:0] held_bit,      held_bit_next;
  logic [7:0] release_code,  release_code_next;
  logic [2:0] relay_bits,    relay_bits_next;
  logic       power_flag,    power_flag_next;

  logic                 prev_write;
  logic [ROW_IDX_W-1:0] row_idx;
  logic [7:0]           prev;
  logic [7:0]           code;
  logic [7:0]           enc_code;
  logic [3:0]           count_new;
  logic [3:0]           need;
  logic [6:0]           cmd_key;
  logic [1:0]           relay_idx;
  logic                 take;

  // one encoder pair: left on the lower bit rising, right on the upper
  function automatic logic [7:0] decode_pair(input logic [1:0] now, input logic [1:0] was,
                                             input logic [7:0] base);
    logic [7:0] c;
    c = 8'h00;
    if (base != 8'h00 && now == 2'b11) begin
      if (!was[0]) c = base;
      if (!was[1]) c = base | pkes_pkg::RIGHT_FLAG;
    end
    return c;
  endfunction

  assign take    = !result_valid || result_ready;
  assign q_pop   = q_valid && take;
  assign row_idx = q_word.row[ROW_IDX_W-1:0];
  assign prev    = q_word.row_ok ? row_previous[row_idx] : 8'hFF;

  // encoder decode, second pair only when the first is quiet
  always_comb begin
    enc_code = decode_pair(q_word.sample[2:1], prev[2:1], q_word.enc_first);
    if (enc_code == 8'h00) begin
      enc_code = decode_pair(q_word.sample[5:4], prev[5:4], q_word.enc_second);
    end
  end

  // qualify count and required count
  always_comb begin
    if (qualify_count != 4'd0 && qualify_row == q_word.row
        && qualify_value == q_word.sample) begin
      count_new = (qualify_count == pkes_pkg::COUNT_MAX) ? qualify_count
                                                           : qualify_count + 4'd1;
    end else begin
      count_new = 4'd1;
    end
    need = q_word.button_need ? button_confirm : encoder_confirm;
    if (need == 4'd0) need = 4'd1;
  end

  assign cmd_key   = q_word.command[6:0];
  assign relay_idx = cmd_key[1:0] - 2'd1;

  // per-word update
  always_comb begin
    qualify_row_next   = qualify_row;
    qualify_value_next = qualify_value;
    qualify_count_next = qualify_count;
    key_held_next      = key_held;
    held_row_next      = held_row;
    held_bit_next      = held_bit;
    release_code_next  = release_code;
    relay_bits_next    = relay_bits;
    power_flag_next    = power_flag;
    prev_write         = 1'b0;
    code               = 8'h00;
    if (q_word.is_command) begin
      if (cmd_key inside {[pkes_pkg::CMD_RELAY_ONE:pkes_pkg::CMD_RELAY_SYNC]}) begin
        relay_bits_next[relay_idx] = q_word.command[7];
      end else if (cmd_key == pkes_pkg::CMD_POWER_OFF && power_flag) begin
        relay_bits_next = 3'b000;
        power_flag_next = 1'b0;
      end
    end else if (q_word.row_ok) begin
      if (key_held) begin
        // waiting for the held bit to come back
        if (q_word.row == held_row && q_word.sample[held_bit]) begin
          key_held_next = 1'b0;
          prev_write    = 1'b1;
          code          = release_code;
        end
      end else if (q_word.sample == prev) begin
        if (qualify_row == q_word.row) qualify_count_next = 4'd0;
      end else begin
        qualify_row_next   = q_word.row;
        qualify_value_next = q_word.sample;
        if (count_new < need) begin
          qualify_count_next = count_new;
        end else begin
          qualify_count_next = 4'd0;
          // accepted row value
          if (q_word.press_found) begin
            if (q_word.press_code == pkes_pkg::POWER_KEY) begin
              if (!power_flag) begin
                power_flag_next   = 1'b1;
                key_held_next     = 1'b1;
                held_row_next     = q_word.row;
                held_bit_next     = q_word.press_bit;
                release_code_next = 8'h00;
              end else begin
                prev_write = 1'b1;
                code       = pkes_pkg::POWER_ON_CODE;
              end
            end else begin
              key_held_next     = 1'b1;
              held_row_next     = q_word.row;
              held_bit_next     = q_word.press_bit;
              release_code_next = q_word.press_code & pkes_pkg::RELEASE_MASK;
              code              = q_word.press_code;
            end
          end else begin
            prev_write = 1'b1;
            code       = enc_code;
          end
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      button_confirm  <= pkes_pkg::BUTTON_CONFIRM_RESET;
      encoder_confirm <= pkes_pkg::ENCODER_CONFIRM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        pkes_pkg::REG_BUTTON_CONFIRM:  button_confirm  <= cfg_data;
        pkes_pkg::REG_ENCODER_CONFIRM: encoder_confirm <= cfg_data;
        default: ;
      endcase
    end
  end

  // stored row states
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS_USED; i++) row_previous[i] <= 8'hFF;
    end else if (q_pop && prev_write) begin
      row_previous[row_idx] <= q_word.sample;
    end
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      qualify_row   <= 3'd0;
      qualify_value <= 8'h00;
      qualify_count <= 4'd0;
      key_held      <= 1'b0;
      held_row      <= 3'd0;
      held_bit      <= 3'd0;
      release_code  <= 8'h00;
      relay_bits    <= 3'b000;
      power_flag    <= 1'b0;
    end else if (q_pop) begin
      qualify_row   <= qualify_row_next;
      qualify_value <= qualify_value_next;
      qualify_count <= qualify_count_next;
      key_held      <= key_held_next;
      held_row      <= held_row_next;
      held_bit      <= held_bit_next;
      release_code  <= release_code_next;
      relay_bits    <= relay_bits_next;
      power_flag    <= power_flag_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result.code_valid     <= (code != 8'h00);
      result.key_code       <= code;
      result.relay_one_low  <= relay_bits_next[0];
      result.relay_two_low  <= relay_bits_next[1];
      result.relay_sync_low <= relay_bits_next[2];
      result.power_on       <= power_flag_next;
    end
  end

`ifndef SYNTH
  a_code_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.code_valid == (result.key_code != 8'h00)))
    else $error("code_valid does not match key_code");

  a_power_holds: assert property (@(posedge clk) disable iff (rst)
    $rose(power_flag) |-> $rose(key_held))
    else $error("power came on without holding the power key");

  a_release_word: assert property (@(posedge clk) disable iff (rst)
    $fell(key_held) |-> (result.key_code == $past(release_code)))
    else $error("release did not emit the stored release code");
`endif

endmodule

### design/panel_key_encoder_scanner.sv
// Top level of the panel key and encoder scanner: front classifier, queue, back end.
// Depends on pkes_pkg, pkes_front, pkes_queue and pkes_back.
//
// Takes one word per cycle while item_ready is high, either a scan row sample or a
// host command byte, and returns exactly one result word for each. A word moves
// through the combinational classifier into a two-entry queue, and the back end
// retires one queued word per cycle into the output register while that register is
// empty or result_ready is high. The queue is registered and so is the output, and
// the block sustains one word per cycle as long as result_ready stays high. The back
// end's state update (row state, qualify count, key hold, relays, power) is what sets
// that rate. Row states reset to all released; the confirm counts are written through
// the cfg port, which the user must do only while idle; the block does not enforce it.
module panel_key_encoder_scanner #(
  parameter int SCAN_ROWS = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  pkes_pkg::in_word_t               item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output pkes_pkg::out_word_t              result,
  input  logic                             cfg_write,
  input  logic [pkes_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pkes_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pkes_pkg::cls_word_t cls;
  pkes_pkg::cls_word_t q_word;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  logic                push;

  assign item_ready = !q_full;
  assign push       = item_valid && item_ready;

  // classify incoming word
  pkes_front #(
    .SCAN_ROWS(SCAN_ROWS)
  ) u_front (
    .word(item),
    .cls (cls)
  );

  // decoupling queue
  pkes_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_word(cls),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .pop_word (q_word)
  );

  // state update and output register
  pkes_back #(
    .SCAN_ROWS(SCAN_ROWS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_valid     (q_valid),
    .q_word      (q_word),
    .q_pop       (q_pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule
